// File: rtl/core/spq_pkg.sv
// Shared constants and types for the sorted priority queue.
`default_nettype none
package spq_pkg;

	// Default sizes
	localparam int DEF_QUEUE_DEPTH   = 16;
	localparam int DEF_PRIORITY_BITS = 16;
	localparam int DEF_DATA_BITS     = 32;

	localparam int CMD_BITS    = 2;
	localparam int STATUS_BITS = 2;

	// Command codes
	localparam logic [CMD_BITS-1:0] CMD_ENQ  = 2'd0;
	localparam logic [CMD_BITS-1:0] CMD_DEQ  = 2'd1;
	localparam logic [CMD_BITS-1:0] CMD_PEEK = 2'd2;

	// Status codes
	localparam logic [STATUS_BITS-1:0] ST_OK    = 2'd0;
	localparam logic [STATUS_BITS-1:0] ST_EMPTY = 2'd1;
	localparam logic [STATUS_BITS-1:0] ST_FULL  = 2'd2;

	// Operation broadcast to every cell of the chain
	typedef struct packed {
		logic enq;
		logic deq;
	} spq_op_t;

endpackage
`default_nettype wire

// File: rtl/core/spq_if.sv
// Handshake interfaces for the command and result channels.
`default_nettype none
interface spq_cmd_if
	import spq_pkg::*;
#(
	parameter int PRIORITY_BITS = DEF_PRIORITY_BITS,
	parameter int DATA_BITS     = DEF_DATA_BITS
) ();
	logic                            valid;
	logic                            ready;
	logic [CMD_BITS-1:0]             cmd;
	logic signed [PRIORITY_BITS-1:0] priority_req;
	logic [DATA_BITS-1:0]            item_data;

	modport source (output valid, cmd, priority_req, item_data, input ready);
	modport sink (input valid, cmd, priority_req, item_data, output ready);
endinterface

interface spq_rsp_if
	import spq_pkg::*;
#(
	parameter int PRIORITY_BITS = DEF_PRIORITY_BITS,
	parameter int DATA_BITS     = DEF_DATA_BITS,
	parameter int COUNT_BITS    = $clog2(DEF_QUEUE_DEPTH + 1)
) ();
	logic                            valid;
	logic                            ready;
	logic [STATUS_BITS-1:0]          status;
	logic [DATA_BITS-1:0]            out_data;
	logic signed [PRIORITY_BITS-1:0] head_priority;
	logic [COUNT_BITS-1:0]           entry_count;

	modport source (output valid, status, out_data, head_priority, entry_count, input ready);
	modport sink (input valid, status, out_data, head_priority, entry_count, output ready);
endinterface
`default_nettype wire

// File: rtl/core/spq_cell.sv
// One slot of the sorted chain: holds an entry, shifts left or right, or takes the new entry.
`default_nettype none
module spq_cell
	import spq_pkg::*;
#(
	parameter int PRIORITY_BITS = DEF_PRIORITY_BITS,
	parameter int DATA_BITS     = DEF_DATA_BITS
) (
	input  wire logic                            clk,
	input  wire spq_op_t                         op,
	input  wire logic                            occupied,
	input  wire logic signed [PRIORITY_BITS-1:0] new_prio,
	input  wire logic [DATA_BITS-1:0]            new_data,
	input  wire logic                            left_behind,
	input  wire logic signed [PRIORITY_BITS-1:0] left_prio,
	input  wire logic [DATA_BITS-1:0]            left_data,
	input  wire logic signed [PRIORITY_BITS-1:0] right_prio,
	input  wire logic [DATA_BITS-1:0]            right_data,
	output logic                                 behind,
	output logic signed [PRIORITY_BITS-1:0]      prio,
	output logic [DATA_BITS-1:0]                 data,
	output logic signed [PRIORITY_BITS-1:0]      prio_next
);

	logic signed [PRIORITY_BITS-1:0] prio_q;
	logic [DATA_BITS-1:0]            data_q;
	logic [DATA_BITS-1:0]            data_next;

	// New entry goes behind this one when this one is held and not greater
	assign behind = occupied && (prio_q <= new_prio);

	// Pick the next content: keep, take the new entry, or shift from a neighbour
	always_comb begin
		prio_next = prio_q;
		data_next = data_q;
		if (op.enq) begin
			if (!behind) begin
				if (left_behind) begin
					prio_next = new_prio;
					data_next = new_data;
				end else begin
					prio_next = left_prio;
					data_next = left_data;
				end
			end
		end else if (op.deq) begin
			prio_next = right_prio;
			data_next = right_data;
		end
	end

	always_ff @(posedge clk) begin
		prio_q <= prio_next;
		data_q <= data_next;
	end

	assign prio = prio_q;
	assign data = data_q;

endmodule
`default_nettype wire

// File: rtl/core/sorted_priority_queue_unit.sv
// Sorted min-priority queue built as a chain of compare-and-shift cells.
// Each accepted command (enqueue, dequeue, peek) gives one result, held in an output register;
// one command is taken every cycle while the result side keeps up, since every cell
// compares its entry with the new priority in parallel and shifts by one slot in the same cycle.
// Equal priorities leave in arrival order. A full queue rejects enqueue with status full; an
// empty queue answers dequeue and peek with status empty. Slots beyond the entry count hold
// stale contents and are never reported.
`default_nettype none
module sorted_priority_queue_unit
	import spq_pkg::*;
#(
	parameter int QUEUE_DEPTH   = DEF_QUEUE_DEPTH,
	parameter int PRIORITY_BITS = DEF_PRIORITY_BITS,
	parameter int DATA_BITS     = DEF_DATA_BITS,
	parameter int COUNT_BITS    = $clog2(QUEUE_DEPTH + 1)
) (
	input  wire logic clk,
	input  wire logic arst_n,
	spq_cmd_if.sink   req,
	spq_rsp_if.source rsp
);

	localparam logic [COUNT_BITS-1:0] FULL_COUNT = COUNT_BITS'(QUEUE_DEPTH);

	logic [COUNT_BITS-1:0] count_q;
	logic [COUNT_BITS-1:0] count_d;
	logic                  rsp_valid_q;
	logic [STATUS_BITS-1:0] status_q;
	logic [DATA_BITS-1:0]  out_data_q;
	logic signed [PRIORITY_BITS-1:0] head_q;
	logic [COUNT_BITS-1:0] entry_count_q;

	logic fire;
	logic is_enq;
	logic is_deq;
	logic is_peek;
	logic full;
	logic empty;
	spq_op_t op;
	logic [STATUS_BITS-1:0] status_d;
	logic [DATA_BITS-1:0]   out_data_d;
	logic signed [PRIORITY_BITS-1:0] head_d;

	logic                            occ_a       [QUEUE_DEPTH];
	logic                            behind_a    [QUEUE_DEPTH];
	logic signed [PRIORITY_BITS-1:0] prio_a      [QUEUE_DEPTH];
	logic [DATA_BITS-1:0]            data_a      [QUEUE_DEPTH];
	logic signed [PRIORITY_BITS-1:0] prio_next_a [QUEUE_DEPTH];

	// Accept while the result register is free or being emptied
	assign req.ready = !rsp_valid_q || rsp.ready;
	assign fire      = req.valid && req.ready;

	// Decode the command
	assign is_enq  = (req.cmd == CMD_ENQ);
	assign is_deq  = (req.cmd == CMD_DEQ);
	assign is_peek = (req.cmd == CMD_PEEK);
	assign full    = (count_q == FULL_COUNT);
	assign empty   = (count_q == '0);
	assign op.enq  = fire && is_enq && !full;
	assign op.deq  = fire && is_deq && !empty;

	// Chain of cells
	for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
		assign occ_a[i] = (COUNT_BITS'(i) < count_q);

		spq_cell #(
			.PRIORITY_BITS(PRIORITY_BITS),
			.DATA_BITS    (DATA_BITS)
		) u_cell (
			.clk        (clk),
			.op         (op),
			.occupied   (occ_a[i]),
			.new_prio   (req.priority_req),
			.new_data   (req.item_data),
			.left_behind((i == 0) ? 1'b1 : behind_a[(i == 0) ? 0 : i - 1]),
			.left_prio  ((i == 0) ? req.priority_req : prio_a[(i == 0) ? 0 : i - 1]),
			.left_data  ((i == 0) ? req.item_data : data_a[(i == 0) ? 0 : i - 1]),
			.right_prio (prio_a[(i == QUEUE_DEPTH - 1) ? i : i + 1]),
			.right_data (data_a[(i == QUEUE_DEPTH - 1) ? i : i + 1]),
			.behind     (behind_a[i]),
			.prio       (prio_a[i]),
			.data       (data_a[i]),
			.prio_next  (prio_next_a[i])
		);
	end

	// Next entry count
	always_comb begin
		count_d = count_q;
		if (op.enq) begin
			count_d = count_q + 1'b1;
		end else if (op.deq) begin
			count_d = count_q - 1'b1;
		end
	end

	// Build the result: status and data from the queue before the command, head priority after it
	always_comb begin
		status_d   = ST_OK;
		out_data_d = '0;
		if (is_enq && full) begin
			status_d = ST_FULL;
		end else if ((is_deq || is_peek) && empty) begin
			status_d = ST_EMPTY;
		end else if (is_deq || is_peek) begin
			out_data_d = data_a[0];
		end
		head_d = (count_d == '0) ? '0 : prio_next_a[0];
	end

	// Hold the count and the result handshake
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (fire) begin
				count_q <= count_d;
			end
			if (fire) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	// Result payload
	always_ff @(posedge clk) begin
		if (fire) begin
			status_q      <= status_d;
			out_data_q    <= out_data_d;
			head_q        <= head_d;
			entry_count_q <= count_d;
		end
	end

	assign rsp.valid         = rsp_valid_q;
	assign rsp.status        = status_q;
	assign rsp.out_data      = out_data_q;
	assign rsp.head_priority = head_q;
	assign rsp.entry_count   = entry_count_q;

	// Checks
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= FULL_COUNT)
		else $error("entry count above queue depth");

	a_deq_count: assert property (@(posedge clk) disable iff (!arst_n)
		(fire && is_deq && !empty) |=> (count_q == $past(count_q) - 1'b1))
		else $error("dequeue did not drop the count");

	a_full_status: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid_q && status_q == ST_FULL) |-> (entry_count_q == FULL_COUNT))
		else $error("full status with room left");

	a_head_sorted: assert property (@(posedge clk) disable iff (!arst_n)
		occ_a[1] |-> (prio_a[0] <= prio_a[1]))
		else $error("head entry out of order");

endmodule
`default_nettype wire
